>>> hdl/lpe_pkg.sv
`default_nettype none

package lpe_pkg;

	localparam int NUM_SENSORS = 16;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = 4;
	localparam int RAW_W       = 16;
	localparam int WGT_W       = 16;
	localparam int TOT_W       = 20;
	localparam int NACC_W      = 20;
	localparam int WACC_W      = 36;
	localparam int POS_W       = 17;
	localparam int NORM_W      = 16;

	// shared divider: remainder/divisor width, dividend bits shifted in, step counter
	localparam int DIV_W       = 20;
	localparam int DVD_W       = 17;
	localparam int CNT_W       = 5;
	localparam logic [CNT_W-1:0] NORM_STEPS = 5'd15;
	localparam logic [CNT_W-1:0] POS_STEPS  = 5'd17;

	localparam logic [POS_W-1:0]  FULL_SCALE = 17'h08000;
	localparam logic [NORM_W-1:0] NORM_FULL  = 16'h8000;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_WHITE  = 2'd1,
		CMD_BLACK  = 2'd2,
		CMD_WEIGHT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SEEN = 2'd0,
		ST_LOST = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic {
		REG_LOST_THRESHOLD     = 1'b0,
		REG_DIRECTION_DEADBAND = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                    we_white;
		logic                    we_black;
		logic                    we_weight;
		logic [IDX_W-1:0]        idx;
		logic [RAW_W-1:0]        raw;
		logic signed [WGT_W-1:0] weight;
	} cal_wr_t;

	typedef struct packed {
		logic [RAW_W-1:0]        white;
		logic [RAW_W-1:0]        black;
		logic signed [WGT_W-1:0] weight;
	} cal_rd_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] den;
		logic [DVD_W-1:0] dvd;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DVD_W-1:0] quo;
	} div_stat_t;

	function automatic logic idx_ok(logic [IDX_W-1:0] i);
		return int'(i) < NUM_SENSORS;
	endfunction

endpackage

`default_nettype wire

>>> hdl/lpe_div.sv
`default_nettype none

module lpe_div
	import lpe_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_req_t  req,
	output div_stat_t      stat
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	// restoring step: one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			den_q <= req.den;
			dvd_q <= req.dvd;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.quo  = quo_q;

endmodule

`default_nettype wire

>>> hdl/lpe_cal.sv
`default_nettype none

module lpe_cal
	import lpe_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cal_wr_t          wr,
	input  wire logic [IDX_W-1:0] rd_idx,
	output cal_rd_t               rd,
	output logic [TOT_W-1:0]      abs_total
);

	logic [RAW_W-1:0]        white_q  [TABLE_DEPTH];
	logic [RAW_W-1:0]        black_q  [TABLE_DEPTH];
	logic signed [WGT_W-1:0] weight_q [TABLE_DEPTH];
	logic [TOT_W-1:0]        total_q;

	logic signed [WGT_W-1:0] old_w;
	logic [TOT_W-1:0]        abs_old;
	logic [TOT_W-1:0]        abs_new;

	always_comb begin
		old_w   = weight_q[wr.idx];
		abs_old = old_w[WGT_W-1] ? TOT_W'(-$signed({old_w[WGT_W-1], old_w}))
		                         : TOT_W'(old_w);
		abs_new = wr.weight[WGT_W-1] ? TOT_W'(-$signed({wr.weight[WGT_W-1], wr.weight}))
		                             : TOT_W'(wr.weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				white_q[i]  <= '0;
				black_q[i]  <= '0;
				weight_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (wr.we_white)
				white_q[wr.idx] <= wr.raw;
			if (wr.we_black)
				black_q[wr.idx] <= wr.raw;
			if (wr.we_weight) begin
				weight_q[wr.idx] <= wr.weight;
				total_q          <= total_q - abs_old + abs_new;
			end
		end
	end

	assign rd.white  = white_q[rd_idx];
	assign rd.black  = black_q[rd_idx];
	assign rd.weight = weight_q[rd_idx];
	assign abs_total = total_q;

endmodule

`default_nettype wire

>>> hdl/line_position_estimator_unit.sv
// channel  dir  signals                           payload
// s_*      in   s_tvalid s_tready s_tdata         tdata: sensor_index, raw_value, weight
//                s_tuser s_tlast                  tuser: command, tlast: frame_end
// m_*      out  m_tvalid m_tready m_tdata m_tuser tdata: position, tuser: status
// cfg_*    in   cfg_we cfg_index cfg_data         lost_threshold, direction_deadband
//
// Calibration and weight commands are written to their tables without leaving idle. A sample
// is normalized by the shared radix-2 divider; a sample at or past its levels skips the divider.
// A sample closing a frame then runs the 17-step position quotient, which is skipped when
// the line is lost, all weights are zero or the quotient saturates.
// Reset clears tables, accumulators, heading and registers to their defaults.
// The result sits in an output register; a new item is taken while it waits, and
// the block stalls only when a second result is ready before the first is taken.
`default_nettype none

module line_position_estimator_unit
	import lpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // sensor_index[3:0], raw_value[19:4], weight[35:20]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // position[16:0]
	output logic [1:0]       m_tuser,   // status[1:0]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [19:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_MUL,
		S_ACC,
		S_FEND,
		S_DIVP,
		S_OUT
	} state_t;

	state_t state_q;

	logic [TOT_W-1:0]  thresh_q;
	logic [15:0]       deadband_q;

	logic                     heading_neg_q;
	logic                     fend_q;
	logic                     neg_q;
	logic [NORM_W-1:0]        n_q;
	logic signed [WGT_W-1:0]  w_q;
	logic signed [32:0]       prod_q;
	logic signed [WACC_W-1:0] wacc_q;
	logic [NACC_W-1:0]        nacc_q;
	logic [POS_W-1:0]         res_pos_q;
	status_t                  res_st_q;
	logic                     m_tvalid_q;
	logic [POS_W-1:0]         m_pos_q;
	status_t                  m_st_q;

	cal_wr_t   cal_wr;
	cal_rd_t   cal_rd;
	logic [TOT_W-1:0] abs_total;
	div_req_t  div_req;
	div_stat_t div_stat;

	logic                    accept;
	cmd_t                    cmd_in;
	logic [IDX_W-1:0]        idx_in;
	logic [RAW_W-1:0]        raw_in;
	logic signed [WGT_W-1:0] w_in;
	logic                    valid_in;
	logic                    trivial;
	logic [NORM_W-1:0]       n_trivial;

	logic [WACC_W-1:0]   mag;
	logic                ovf;
	logic [WACC_W:0]     wsum;
	logic [NACC_W:0]     nsum;
	logic [POS_W-1:0]    posm;
	logic                neg_c;
	logic [POS_W-1:0]    pos_c;
	logic                upd_c;
	logic                out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cmd_in   = cmd_t'(s_tuser);
	assign idx_in   = s_tdata[3:0];
	assign raw_in   = s_tdata[19:4];
	assign w_in     = $signed(s_tdata[35:20]);
	assign valid_in = idx_ok(idx_in);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cal_wr.we_white  = accept && (cmd_in == CMD_WHITE) && valid_in;
		cal_wr.we_black  = accept && (cmd_in == CMD_BLACK) && valid_in;
		cal_wr.we_weight = accept && (cmd_in == CMD_WEIGHT) && valid_in;
		cal_wr.idx       = idx_in;
		cal_wr.raw       = raw_in;
		cal_wr.weight    = w_in;
	end

	lpe_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cal_wr),
		.rd_idx    (idx_in),
		.rd        (cal_rd),
		.abs_total (abs_total)
	);

	always_comb begin
		trivial   = 1'b1;
		n_trivial = '0;
		priority if (cal_rd.black == cal_rd.white || raw_in <= cal_rd.white)
			n_trivial = '0;
		else if (raw_in >= cal_rd.black)
			n_trivial = NORM_FULL;
		else
			trivial = 1'b0;
	end

	always_comb begin
		mag = wacc_q[WACC_W-1] ? WACC_W'(-wacc_q) : WACC_W'(wacc_q);
		ovf = {1'b0, mag[WACC_W-1:DVD_W]} >= abs_total;
	end

	always_comb begin
		div_req = '0;
		if (state_q == S_IDLE) begin
			div_req.start = accept && (cmd_in == CMD_SAMPLE) && valid_in && !trivial;
			div_req.rem   = DIV_W'(raw_in - cal_rd.white);
			div_req.den   = DIV_W'(cal_rd.black - cal_rd.white);
			div_req.dvd   = '0;
			div_req.steps = NORM_STEPS;
		end else begin
			div_req.start = (state_q == S_FEND) && fend_q && !(nacc_q < thresh_q)
			                && (abs_total != '0) && !ovf;
			div_req.rem   = {1'b0, mag[WACC_W-1:DVD_W]};
			div_req.den   = abs_total;
			div_req.dvd   = mag[DVD_W-1:0];
			div_req.steps = POS_STEPS;
		end
	end

	lpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	always_comb begin
		wsum = {wacc_q[WACC_W-1], wacc_q} + (WACC_W+1)'(prod_q);
		nsum = {1'b0, nacc_q} + (NACC_W+1)'(n_q);
		if (state_q == S_FEND) begin
			posm  = FULL_SCALE;
			neg_c = wacc_q[WACC_W-1];
		end else begin
			posm  = (div_stat.quo > FULL_SCALE) ? FULL_SCALE : div_stat.quo;
			neg_c = neg_q;
		end
		pos_c = neg_c ? POS_W'(-posm) : posm;
		upd_c = posm > {1'b0, deadband_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= 20'd2621;
			deadband_q <= 16'd983;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOST_THRESHOLD:     thresh_q   <= cfg_data;
				REG_DIRECTION_DEADBAND: deadband_q <= cfg_data[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			heading_neg_q <= 1'b0;
			wacc_q        <= '0;
			nacc_q        <= '0;
			m_tvalid_q    <= 1'b0;
			fend_q        <= 1'b0;
			neg_q         <= 1'b0;
			n_q           <= '0;
			w_q           <= '0;
			prod_q        <= '0;
			res_pos_q     <= '0;
			res_st_q      <= ST_SEEN;
			m_pos_q       <= '0;
			m_st_q        <= ST_SEEN;
		end else begin
			if (state_q == S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd_in == CMD_SAMPLE) begin
						fend_q <= s_tlast;
						w_q    <= cal_rd.weight;
						n_q    <= n_trivial;
						priority if (!valid_in)
							state_q <= S_FEND;
						else if (trivial)
							state_q <= S_MUL;
						else
							state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!div_stat.busy) begin
						n_q     <= div_stat.quo[NORM_W-1:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, n_q}) * w_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					nacc_q <= nsum[NACC_W] ? '1 : nsum[NACC_W-1:0];
					if (wsum[WACC_W] != wsum[WACC_W-1])
						wacc_q <= wsum[WACC_W] ? {1'b1, {(WACC_W-1){1'b0}}}
						                       : {1'b0, {(WACC_W-1){1'b1}}};
					else
						wacc_q <= wsum[WACC_W-1:0];
					state_q <= S_FEND;
				end
				S_FEND: begin
					if (!fend_q) begin
						state_q <= S_IDLE;
					end else begin
						wacc_q <= '0;
						nacc_q <= '0;
						neg_q  <= wacc_q[WACC_W-1];
						priority if (nacc_q < thresh_q) begin
							res_pos_q <= heading_neg_q ? POS_W'(-FULL_SCALE) : FULL_SCALE;
							res_st_q  <= ST_LOST;
							state_q   <= S_OUT;
						end else if (abs_total == '0) begin
							res_pos_q <= '0;
							res_st_q  <= ST_ZERO;
							state_q   <= S_OUT;
						end else if (ovf) begin
							res_pos_q <= pos_c;
							res_st_q  <= ST_SEEN;
							if (upd_c)
								heading_neg_q <= neg_c;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_DIVP;
						end
					end
				end
				S_DIVP: begin
					if (!div_stat.busy) begin
						res_pos_q <= pos_c;
						res_st_q  <= ST_SEEN;
						if (upd_c)
							heading_neg_q <= neg_c;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_pos_q    <= res_pos_q;
						m_st_q     <= res_st_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, m_pos_q};
	assign m_tuser  = m_st_q;

endmodule

`default_nettype wire

>>> sim/line_position_checker.sv
`default_nettype none

module line_position_checker
	import lpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,   // sensor_index[3:0], raw_value[19:4], weight[35:20]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,   // position[16:0]
	input  wire logic [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [19:0] cfg_data,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WACC_HI = (longint'(1) <<< (WACC_W - 1)) - 1;
	localparam longint WACC_LO = -(longint'(1) <<< (WACC_W - 1));
	localparam longint FS      = 32768;

	typedef struct packed {
		logic [POS_W-1:0] position;
		status_t          status;
	} line_result_t;

	line_result_t            pending_positions[$];

	logic [RAW_W-1:0]        white_lvl[TABLE_DEPTH];
	logic [RAW_W-1:0]        black_lvl[TABLE_DEPTH];
	logic signed [WGT_W-1:0] wgt_tab[TABLE_DEPTH];
	logic [TOT_W-1:0]        wgt_total;
	logic signed [WACC_W-1:0] wacc;
	logic [NACC_W-1:0]       nacc;
	logic                    heading_neg;
	logic [19:0]             lost_thr;
	logic [15:0]             deadband;

	function automatic logic [TOT_W-1:0] weight_mag(logic signed [WGT_W-1:0] w);
		longint v;
		v = longint'(w);
		return (v < 0) ? TOT_W'(-v) : TOT_W'(v);
	endfunction

	function automatic logic [NORM_W-1:0] norm_level(logic [RAW_W-1:0] raw,
			logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
		logic [31:0] num;
		logic [31:0] span;
		if (hi == lo || raw <= lo)
			return '0;
		if (raw >= hi)
			return NORM_FULL;
		num  = ({16'd0, raw} - {16'd0, lo}) << 15;
		span = {16'd0, hi} - {16'd0, lo};
		return NORM_W'(num / span);
	endfunction

	task automatic predict_line_position(cmd_t cmd, logic [IDX_W-1:0] idx,
			logic [RAW_W-1:0] raw, logic signed [WGT_W-1:0] wgt, logic fend);
		logic [NORM_W-1:0] n;
		logic [NACC_W:0]   nsum;
		longint            acc;
		longint            q;
		line_result_t      res;
		case (cmd)
			CMD_WHITE: begin
				if (int'(idx) < NUM_SENSORS)
					white_lvl[idx] = raw;
				return;
			end
			CMD_BLACK: begin
				if (int'(idx) < NUM_SENSORS)
					black_lvl[idx] = raw;
				return;
			end
			CMD_WEIGHT: begin
				if (int'(idx) < NUM_SENSORS) begin
					wgt_total    = wgt_total - weight_mag(wgt_tab[idx]) + weight_mag(wgt);
					wgt_tab[idx] = wgt;
				end
				return;
			end
			default: ;
		endcase

		if (int'(idx) < NUM_SENSORS) begin
			n   = norm_level(raw, white_lvl[idx], black_lvl[idx]);
			acc = longint'(wacc) + longint'(n) * longint'(wgt_tab[idx]);
			if (acc > WACC_HI)
				acc = WACC_HI;
			if (acc < WACC_LO)
				acc = WACC_LO;
			wacc = WACC_W'(acc);
			nsum = {1'b0, nacc} + (NACC_W+1)'(n);
			nacc = nsum[NACC_W] ? '1 : nsum[NACC_W-1:0];
		end
		if (!fend)
			return;

		if (nacc < lost_thr) begin
			q          = heading_neg ? -FS : FS;
			res.status = ST_LOST;
		end else if (wgt_total == 0) begin
			q          = 0;
			res.status = ST_ZERO;
		end else begin
			q = longint'(wacc) / longint'(wgt_total);
			if (q > FS)
				q = FS;
			if (q < -FS)
				q = -FS;
			res.status = ST_SEEN;
			if (q > longint'(deadband))
				heading_neg = 1'b0;
			else if (q < -longint'(deadband))
				heading_neg = 1'b1;
		end
		res.position = q[POS_W-1:0];
		pending_positions.push_back(res);
		wacc = '0;
		nacc = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_result_t exp;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				white_lvl[i] = '0;
				black_lvl[i] = '0;
				wgt_tab[i]   = '0;
			end
			wgt_total   = '0;
			wacc        = '0;
			nacc        = '0;
			heading_neg = 1'b0;
			lost_thr    = 20'd2621;
			deadband    = 16'd983;
			pending_positions.delete();
			errors      = 0;
			pending     = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_positions.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual position %0d status %0d",
						$time, $signed(m_tdata[POS_W-1:0]), m_tuser);
				end else begin
					exp = pending_positions.pop_front();
					if (m_tdata !== {{(24 - POS_W){1'b0}}, exp.position}) begin
						errors++;
						$display("%0t: position mismatch, expected %0d (%h) actual %0d (%h)",
							$time, $signed(exp.position), exp.position,
							$signed(m_tdata[POS_W-1:0]), m_tdata);
					end
					if (m_tuser !== exp.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, exp.status, m_tuser);
					end
				end
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_LOST_THRESHOLD:     lost_thr = cfg_data;
					REG_DIRECTION_DEADBAND: deadband = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_line_position(cmd_t'(s_tuser), s_tdata[3:0], s_tdata[19:4],
					s_tdata[35:20], s_tlast);
			pending = pending_positions.size();
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
	import lpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 1850;
	localparam int HOLD_CYCLES = 500;
	localparam int IDLE_CYCLES = 60;
	localparam int TAIL_CYCLES = 100;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [19:0] cfg_data  = '0;
	int          errors;
	int          pending;

	bit          no_idle  = 1'b0;
	bit          hold_req = 1'b0;
	int          items_sent = 0;
	logic [15:0] white_s[TABLE_DEPTH];
	logic [15:0] black_s[TABLE_DEPTH];

	line_position_estimator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	line_position_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("status: fail");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [15:0] rand_raw(logic [3:0] i);
		int lo;
		int hi;
		int v;
		lo = int'(white_s[i]);
		hi = int'(black_s[i]);
		case ($urandom_range(0, 9))
			4: return white_s[i];
			5: return black_s[i];
			6: v = lo + $urandom_range(0, 300);
			7: v = hi + $urandom_range(0, 300) - 150;
			8: return 16'h0000;
			9: return 16'hFFFF;
			3: v = (hi > lo) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
			default: v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// receiver: random ready, with an occasional long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (no_idle || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	task automatic send_item(cmd_t cmd, logic [3:0] idx, logic [15:0] raw,
			logic [15:0] wgt, logic fend);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'd0, wgt, raw, idx};
		s_tlast  <= fend;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (cmd == CMD_WHITE)
			white_s[idx] = raw;
		if (cmd == CMD_BLACK)
			black_s[idx] = raw;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [19:0] thr, logic [19:0] db);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOST_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= REG_DIRECTION_DEADBAND;
		cfg_data  <= db;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic calibrate();
		int lo;
		int hi;
		int mode;
		int wmode;
		logic [15:0] w;
		wmode = $urandom_range(0, 9);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			mode = $urandom_range(0, 9);
			lo   = $urandom_range(0, 30000);
			hi   = lo + $urandom_range(1, 35535);
			if (mode == 0) begin
				hi = lo;
			end else if (mode == 1) begin
				lo = $urandom_range(20000, 65535);
				hi = $urandom_range(0, 19999);
			end else if (mode == 2) begin
				lo = 0;
				hi = 65535;
			end
			case (wmode)
				0:       w = 16'h0000;
				1, 2:    w = 16'((2 * i - 15) * 2048);
				3:       w = (i < 8) ? 16'h8000 : 16'h7FFF;
				default: w = 16'($urandom);
			endcase
			send_item(CMD_WHITE, 4'(i), lo[15:0], 16'($urandom), 1'($urandom));
			send_item(CMD_BLACK, 4'(i), hi[15:0], 16'($urandom), 1'($urandom));
			send_item(CMD_WEIGHT, 4'(i), 16'($urandom), w, 1'($urandom));
		end
	endtask

	task automatic full_frame();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_item(CMD_SAMPLE, 4'(i), rand_raw(4'(i)), 16'($urandom), i == TABLE_DEPTH - 1);
	endtask

	task automatic random_frame();
		int k;
		int n;
		logic [15:0] v;
		case ($urandom_range(0, 19))
			14: begin
				// mostly at white level: line tends to be lost
				k = $urandom_range(0, 15);
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					v = (i == k) ? white_s[i] + 16'($urandom_range(0, 3000)) : white_s[i];
					send_item(CMD_SAMPLE, 4'(i), v, 16'($urandom), i == TABLE_DEPTH - 1);
				end
			end
			15: begin
				// one sensor hammered at full scale: both accumulators saturate
				k = $urandom_range(0, 15);
				send_item(CMD_WHITE, 4'(k), 16'h0000, 16'($urandom), 1'b0);
				send_item(CMD_BLACK, 4'(k), 16'hFFFF, 16'($urandom), 1'b0);
				send_item(CMD_WEIGHT, 4'(k), 16'($urandom),
					$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 1'b0);
				for (int j = 0; j < 40; j++)
					send_item(CMD_SAMPLE, 4'(k), 16'hFFFF, 16'($urandom), j == 39);
			end
			16: begin
				n = $urandom_range(1, 15);
				for (int j = 0; j < n; j++) begin
					k = $urandom_range(0, 15);
					send_item(CMD_SAMPLE, 4'(k), rand_raw(4'(k)), 16'($urandom), j == n - 1);
				end
			end
			17: begin
				send_item(cmd_t'($urandom_range(1, 3)), 4'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom));
				full_frame();
			end
			18, 19: begin
				n = $urandom_range(1, 6);
				for (int j = 0; j < n; j++)
					send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
						16'($urandom), 1'($urandom));
			end
			default: full_frame();
		endcase
	endtask

	initial begin
		int phase;
		logic [19:0] thr;
		logic [19:0] db;

		for (int i = 0; i < TABLE_DEPTH; i++) begin
			white_s[i] = '0;
			black_s[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, equal levels, at white, at black, weight extremes
		send_item(CMD_SAMPLE, 4'd3, 16'd0, 16'h0000, 1'b1);
		send_item(CMD_WHITE, 4'd3, 16'd100, 16'h0000, 1'b0);
		send_item(CMD_BLACK, 4'd3, 16'd100, 16'h0000, 1'b0);
		send_item(CMD_SAMPLE, 4'd3, 16'd200, 16'h0000, 1'b1);
		send_item(CMD_BLACK, 4'd3, 16'hFFFF, 16'h0000, 1'b0);
		send_item(CMD_SAMPLE, 4'd3, 16'd100, 16'h0000, 1'b1);
		send_item(CMD_SAMPLE, 4'd3, 16'hFFFF, 16'h0000, 1'b1);
		send_item(CMD_WEIGHT, 4'd3, 16'h0000, 16'h8000, 1'b0);
		send_item(CMD_SAMPLE, 4'd3, 16'hFFFF, 16'h0000, 1'b1);
		send_item(CMD_SAMPLE, 4'd3, 16'd0, 16'hFFFF, 1'b1);
		send_item(CMD_SAMPLE, 4'd3, 16'd32867, 16'h0000, 1'b1);
		send_item(CMD_WEIGHT, 4'd3, 16'hFFFF, 16'h7FFF, 1'b0);
		send_item(CMD_SAMPLE, 4'd3, 16'hFFFF, 16'h0000, 1'b1);
		// black below white; frame end on a non-sample command is ignored
		send_item(CMD_WHITE, 4'd4, 16'd5000, 16'h0000, 1'b1);
		send_item(CMD_BLACK, 4'd4, 16'd1000, 16'h0000, 1'b1);
		send_item(CMD_WEIGHT, 4'd4, 16'h0000, 16'h1000, 1'b1);
		send_item(CMD_SAMPLE, 4'd4, 16'd3000, 16'h0000, 1'b1);
		send_item(CMD_SAMPLE, 4'd4, 16'd6000, 16'h0000, 1'b0);
		send_item(CMD_SAMPLE, 4'd15, 16'hFFFF, 16'h0000, 1'b1);
		send_item(CMD_WEIGHT, 4'd3, 16'h0000, 16'h0000, 1'b0);
		send_item(CMD_WEIGHT, 4'd4, 16'h0000, 16'h0000, 1'b0);
		send_item(CMD_SAMPLE, 4'd4, 16'hFFFF, 16'h0000, 1'b1);

		phase = 0;
		while (items_sent < ITEMS) begin
			go_idle();
			case (phase)
				0: begin thr = 20'd2621;   db = 20'd983;   end
				1: begin thr = 20'd0;      db = 20'd0;     end
				2: begin thr = 20'd524288; db = 20'd32768; end
				3: begin thr = 20'd0;      db = 20'd32768; end
				4: begin thr = 20'd524288; db = 20'd0;     end
				default: begin
					thr = 20'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 524288)
						: $urandom_range(0, 20000));
					db  = 20'($urandom_range(0, 32768));
				end
			endcase
			write_config(thr, db);
			no_idle = ($urandom_range(0, 3) == 0);
			calibrate();
			if (phase == 1) begin
				// results pile up behind a stalled receiver
				no_idle  = 1'b1;
				hold_req = 1'b1;
				for (int j = 0; j < 30; j++)
					send_item(CMD_SAMPLE, 4'($urandom), 16'($urandom), 16'($urandom), 1'b1);
				no_idle = 1'b0;
			end
			repeat ($urandom_range(8, 12)) random_frame();
			phase++;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
